### design/indexed_insert_remove_array_core_defines.svh
// ----------------------------------------------------------------------------
// indexed insert/remove array - assertion macros
// shared property macros for the checker
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_ARRAY_CORE_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IIRA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iira assertion failed");

// antecedent implies consequent in the next cycle
`define IIRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iira assertion failed");

`endif

### design/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg
// types, codes and constants of the indexed insert/remove array
// ----------------------------------------------------------------------------
package iira_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int KIND_W       = 2;
    localparam int POS_W        = 5;
    localparam int WORD_W       = 32;
    localparam int ITEM_COUNT_W = 5;
    localparam int STATUS_W     = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] new_value;
    } req_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [ITEM_COUNT_W-1:0]  item_count;
        logic [STATUS_W-1:0]      status;
    } rsp_item_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

### design/iira_ctrl.sv
// ----------------------------------------------------------------------------
// iira_ctrl
// handshake controller: takes a request, runs it once the result slot is free
// ----------------------------------------------------------------------------
module iira_ctrl
    import iira_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        slot_free;

    // result slot can take a new result if empty or drained this cycle
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            CTRL_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            CTRL_EXEC:
            begin
                cmd.execute = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### design/iira_dp.sv
// ----------------------------------------------------------------------------
// iira_dp
// entry register array with per-slot shift muxes, count and result register
// ----------------------------------------------------------------------------
module iira_dp
    import iira_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    input  req_item_t req,
    output rsp_item_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [KIND_W-1:0]        kind_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [WORD_W-1:0] word_reg;

    logic signed [WORD_W-1:0] entries_reg  [CAPACITY];
    logic signed [WORD_W-1:0] entries_next [CAPACITY];
    logic signed [WORD_W-1:0] up_src       [CAPACITY];
    logic signed [WORD_W-1:0] dn_src       [CAPACITY];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    rsp_item_t                rsp_reg;
    rsp_item_t                rsp_next;

    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         at_ext;
    logic                     full;
    logic                     empty;
    logic                     do_ins;
    logic                     do_rem;
    logic signed [WORD_W-1:0] read_sel;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    // remove at count drops the last entry
    assign at_ext  = (pos_ext == cnt_ext) ? (cnt_ext - CMP_W'(1)) : pos_ext;

    // neighbour taps for the shift muxes
    always_comb
    begin
        up_src[0]          = '0;
        dn_src[CAPACITY-1] = '0;
        for (int i = 1; i < CAPACITY; i++)
        begin
            up_src[i] = entries_reg[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            dn_src[i] = entries_reg[i+1];
        end
    end

    always_comb
    begin
        read_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pos_ext == CMP_W'(i))
            begin
                read_sel = read_sel | entries_reg[i];
            end
        end
    end

    always_comb
    begin
        do_ins              = 1'b0;
        do_rem              = 1'b0;
        rsp_next.read_value = '0;
        rsp_next.status     = STATUS_OK;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    rsp_next.status = STATUS_RANGE;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (empty)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else if (pos_ext > cnt_ext)
                begin
                    rsp_next.status = STATUS_RANGE;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    rsp_next.read_value = read_sel;
                end
                else
                begin
                    rsp_next.status = STATUS_RANGE;
                end
            end
            default:
            begin
                rsp_next.status = STATUS_OK;
            end
        endcase

        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
        rsp_next.item_count = ITEM_COUNT_W'(count_next);
    end

    // slots at and above count hold zero, so shifting in from there clears
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_ins)
            begin
                if (CMP_W'(i) > pos_ext)
                begin
                    entries_next[i] = up_src[i];
                end
                else if (CMP_W'(i) == pos_ext)
                begin
                    entries_next[i] = word_reg;
                end
            end
            else if (do_rem)
            begin
                if (CMP_W'(i) >= at_ext)
                begin
                    entries_next[i] = dn_src[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req.kind;
            pos_reg  <= req.position;
            word_reg <= req.new_value;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

### design/indexed_insert_remove_array_core.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_core
// ordered list of signed words with insert, remove and read at an index
// ----------------------------------------------------------------------------
// request channel req_valid/req_ready carries kind, position and new_value;
// response channel rsp_valid/rsp_ready carries read_value, item_count, status.
// every request gives exactly one response, in order.
// a request is captured when taken and executed in the EXEC state once the
// result slot is free, which a waiting response can stall; the execute step
// then sets the rsp_valid register together with the response register. a
// new request is taken only after the previous one has executed, through the
// capture and execute steps of the controller around the single entry array update.
// the response sits in an output register: a new request is taken while it
// waits, but execution holds until the receiver has drained the register,
// and req_ready stays low meanwhile.
// reset empties the list, clears every entry to zero and drops rsp_valid.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array_core
    import iira_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    ctrl_cmd_t cmd;

    iira_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    iira_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

### design/iira_checker.sv
// ----------------------------------------------------------------------------
// iira_checker
// port-level checks of the indexed insert/remove array, bound to the top
// ----------------------------------------------------------------------------
`include "indexed_insert_remove_array_core_defines.svh"

module iira_checker
    import iira_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    localparam logic [ITEM_COUNT_W-1:0] FULL_COUNT = ITEM_COUNT_W'(CAPACITY);

    logic req_xfer;
    logic rsp_empty;
    logic rsp_full;

    assign req_xfer  = req_valid && req_ready;
    assign rsp_empty = rsp_valid && (rsp.status == STATUS_EMPTY);
    assign rsp_full  = rsp_valid && (rsp.status == STATUS_FULL);

    // a stalled response holds its payload
    `IIRA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one request in flight: ready drops after each request transaction
    `IIRA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_xfer, !req_ready)

    // a fresh response is checked against an earlier request transaction
    `IIRA_ASSERT_SAME(a_rsp_cause, clk, rst_n, $rose(rsp_valid), $past(req_xfer, 2))

    // flags agree with the count reported
    `IIRA_ASSERT_SAME(a_empty_count, clk, rst_n, rsp_empty, rsp.item_count == '0)

    `IIRA_ASSERT_SAME(a_full_count, clk, rst_n, rsp_full, rsp.item_count == FULL_COUNT)

endmodule

bind indexed_insert_remove_array_core iira_checker #(
    .CAPACITY (CAPACITY)
) u_iira_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
